// File: src/ps2mct_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// No dependencies; every other file of the block imports this package.
package ps2mct_pkg;

   // Bits of the first (flags) byte of a mouse packet.
   localparam int SYNC_BIT  = 3;
   localparam int XSIGN_BIT = 4;
   localparam int YSIGN_BIT = 5;
   localparam int XOVF_BIT  = 6;
   localparam int YOVF_BIT  = 7;
   localparam int BTN_BITS  = 3;

   localparam int CFG_BITS = 13;

   // Configuration register indexes.
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;

   // Position within a three-byte packet.
   localparam logic [1:0] POS_FLAGS = 2'd0;
   localparam logic [1:0] POS_X     = 2'd1;
   localparam logic [1:0] POS_Y     = 2'd2;

   // A complete packet without overflow, handed from framing to the cursor logic.
   typedef struct packed {
      logic       valid;
      logic [7:0] flags;
      logic [7:0] x_byte;
      logic [7:0] y_byte;
   } packet_type;

endpackage

// File: src/ps2mct_assembler.sv
// Input register and three-byte packet framing for the PS/2 mouse tracker.
// Depends on ps2mct_pkg.
module ps2mct_assembler
   import ps2mct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_from_aux,
   input  logic       advance,
   output packet_type packet,
   output logic       hold_valid,
   output logic [1:0] frame_pos
);

   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_byte_ff;
   logic       hold_aux_ff;
   logic [1:0] pos_ff, pos_in;
   logic [7:0] flags_ff, flags_in;
   logic [7:0] x_byte_ff, x_byte_in;
   logic       step;

   assign req_stall     = hold_valid_ff && !advance;
   assign hold_valid_in = req_stall ? hold_valid_ff : req_valid;
   assign step          = hold_valid_ff && advance && hold_aux_ff;

   always_comb begin
      pos_in         = pos_ff;
      flags_in       = flags_ff;
      x_byte_in      = x_byte_ff;
      packet.valid   = 1'b0;
      packet.flags   = flags_ff;
      packet.x_byte  = x_byte_ff;
      packet.y_byte  = hold_byte_ff;
      if (step) begin
         unique case (pos_ff)
            POS_X: begin
               x_byte_in = hold_byte_ff;
               pos_in    = POS_Y;
            end
            POS_Y: begin
               pos_in       = POS_FLAGS;
               packet.valid = !flags_ff[XOVF_BIT] && !flags_ff[YOVF_BIT];
            end
            default: begin
               // A first byte must carry the sync bit; anything else is dropped.
               if (hold_byte_ff[SYNC_BIT]) begin
                  flags_in = hold_byte_ff;
                  pos_in   = POS_X;
               end else begin
                  pos_in = POS_FLAGS;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         pos_ff        <= POS_FLAGS;
         flags_ff      <= 8'd0;
         x_byte_ff     <= 8'd0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         pos_ff        <= pos_in;
         flags_ff      <= flags_in;
         x_byte_ff     <= x_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         hold_byte_ff <= req_data_byte;
         hold_aux_ff  <= req_from_aux;
      end
   end

   assign hold_valid = hold_valid_ff;
   assign frame_pos  = pos_ff;

endmodule

// File: src/ps2mct_cursor.sv
// Delta forming, cursor clamping and the result register of the mouse tracker.
// Depends on ps2mct_pkg.
module ps2mct_cursor
   import ps2mct_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  packet_type            packet,
   input  logic [CFG_BITS-1:0]   screen_width,
   input  logic [CFG_BITS-1:0]   screen_height,
   output logic                  rsp_valid,
   output logic signed [8:0]     rsp_delta_x,
   output logic signed [9:0]     rsp_delta_y,
   output logic [BTN_BITS-1:0]   rsp_button_bits,
   output logic [COORD_BITS-1:0] rsp_cursor_x,
   output logic [COORD_BITS-1:0] rsp_cursor_y,
   output logic [BTN_BITS-1:0]   rsp_buttons_changed
);

   localparam int SizeBits = COORD_BITS + 1;
   localparam int SumBits  = COORD_BITS + 2;
   localparam int CmpBits  = (SizeBits > CFG_BITS) ? SizeBits : CFG_BITS;
   localparam int TopSize  = 1 << COORD_BITS;
   localparam int RstX = ((int'(SCREEN_WIDTH_RESET) > TopSize) ? TopSize
                                                               : int'(SCREEN_WIDTH_RESET)) / 2;
   localparam int RstY = ((int'(SCREEN_HEIGHT_RESET) > TopSize) ? TopSize
                                                                : int'(SCREEN_HEIGHT_RESET)) / 2;

   // A size of zero acts as one; one beyond the coordinate range acts as the range.
   function automatic logic [SizeBits-1:0] effective_size(input logic [CFG_BITS-1:0] reg_val);
      logic [CmpBits-1:0] ext;
      logic [CmpBits-1:0] top;
      logic [CmpBits-1:0] res;
      ext = CmpBits'(reg_val);
      top = CmpBits'(1) << COORD_BITS;
      if (ext == '0) begin
         res = CmpBits'(1);
      end else if (ext > top) begin
         res = top;
      end else begin
         res = ext;
      end
      return SizeBits'(res);
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_axis(input logic signed [SumBits-1:0] v,
                                                         input logic [SizeBits-1:0] size);
      logic [SizeBits-1:0] size_m1;
      logic [COORD_BITS-1:0] res;
      size_m1 = size - SizeBits'(1);
      if (v[SumBits-1]) begin
         res = '0;
      end else if (v[SizeBits-1:0] >= size) begin
         res = size_m1[COORD_BITS-1:0];
      end else begin
         res = v[COORD_BITS-1:0];
      end
      return res;
   endfunction

   logic [COORD_BITS-1:0]   pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]   pos_y_ff, pos_y_in;
   logic [BTN_BITS-1:0]     last_btn_ff, last_btn_in;
   logic                    valid_ff;
   logic signed [8:0]       dx;
   logic signed [9:0]       dy;
   logic signed [SumBits-1:0] sum_x, sum_y;
   logic [BTN_BITS-1:0]     buttons;
   logic                    take;

   // The sign bit in the flags byte is the ninth bit of a two's complement count.
   assign dx      = {packet.flags[XSIGN_BIT], packet.x_byte};
   assign dy      = 10'sd0 - {packet.flags[YSIGN_BIT], packet.flags[YSIGN_BIT], packet.y_byte};
   assign sum_x   = $signed({2'b00, pos_x_ff}) + SumBits'(dx);
   assign sum_y   = $signed({2'b00, pos_y_ff}) + SumBits'(dy);
   assign buttons = packet.flags[BTN_BITS-1:0];
   assign take    = advance && packet.valid;

   always_comb begin
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      last_btn_in = last_btn_ff;
      if (take) begin
         pos_x_in    = clamp_axis(sum_x, effective_size(screen_width));
         pos_y_in    = clamp_axis(sum_y, effective_size(screen_height));
         last_btn_in = buttons;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pos_x_ff    <= COORD_BITS'(RstX);
         pos_y_ff    <= COORD_BITS'(RstY);
         last_btn_ff <= '0;
      end else begin
         if (advance) begin
            valid_ff <= packet.valid;
         end
         pos_x_ff    <= pos_x_in;
         pos_y_ff    <= pos_y_in;
         last_btn_ff <= last_btn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_delta_x         <= dx;
         rsp_delta_y         <= dy;
         rsp_button_bits     <= buttons;
         rsp_cursor_x        <= pos_x_in;
         rsp_cursor_y        <= pos_y_in;
         rsp_buttons_changed <= buttons ^ last_btn_ff;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

// File: src/ps2_mouse_packet_cursor_tracker.sv
// PS/2 mouse packet cursor tracker: takes one controller byte per cycle unless
// stalled, frames three-byte mouse packets and moves a clamped cursor. A request
// is registered on acceptance and its result, if any, enters the result register.
// One request can be accepted every cycle; the rate is set by the single
// register-to-register pass through the cursor adder and clamp. A stalled result
// holds the pipeline, with one further request taken into the input register.
// Keyboard bytes, bytes lost while resynchronising and packets with an overflow
// flag give no result. Write screen size registers through the csr port only while
// the block is idle, which it does not check; they take effect at the next packet.
// Depends on ps2mct_pkg, ps2mct_assembler and ps2mct_cursor.
module ps2_mouse_packet_cursor_tracker
   import ps2mct_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_from_aux,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [8:0]     rsp_delta_x,
   output logic signed [9:0]     rsp_delta_y,
   output logic [BTN_BITS-1:0]   rsp_button_bits,
   output logic [COORD_BITS-1:0] rsp_cursor_x,
   output logic [COORD_BITS-1:0] rsp_cursor_y,
   output logic [BTN_BITS-1:0]   rsp_buttons_changed,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CFG_BITS-1:0]   csr_data
);

   logic [CFG_BITS-1:0] width_ff, width_in;
   logic [CFG_BITS-1:0] height_ff, height_in;
   logic                advance;
   logic                hold_valid;
   logic [1:0]          frame_pos;
   packet_type          packet;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  width_in  = csr_data;
            REG_SCREEN_HEIGHT: height_in = csr_data;
            default:           width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Work moves on unless a finished result is waiting and stalled.
   assign advance = !(rsp_valid && rsp_stall);

   ps2mct_assembler u_assembler (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_from_aux  (req_from_aux),
      .advance       (advance),
      .packet        (packet),
      .hold_valid    (hold_valid),
      .frame_pos     (frame_pos)
   );

   ps2mct_cursor #(
      .COORD_BITS (COORD_BITS)
   ) u_cursor (
      .clock               (clock),
      .reset               (reset),
      .advance             (advance),
      .packet              (packet),
      .screen_width        (width_ff),
      .screen_height       (height_ff),
      .rsp_valid           (rsp_valid),
      .rsp_delta_x         (rsp_delta_x),
      .rsp_delta_y         (rsp_delta_y),
      .rsp_button_bits     (rsp_button_bits),
      .rsp_cursor_x        (rsp_cursor_x),
      .rsp_cursor_y        (rsp_cursor_y),
      .rsp_buttons_changed (rsp_buttons_changed)
   );

   a_stall_needs_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> hold_valid)
      else $error("request stalled with an empty input register");

   a_frame_pos_legal: assert property (@(posedge clock) disable iff (reset)
      frame_pos != 2'd3)
      else $error("packet byte position out of range");

   a_frame_frozen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(frame_pos))
      else $error("framing advanced while the result was stalled");

   a_packet_only_on_last: assert property (@(posedge clock) disable iff (reset)
      packet.valid |-> (frame_pos == POS_Y && hold_valid))
      else $error("packet completed away from its third byte");

endmodule
